>>> src/gsed_pkg.sv
// Shared types, constants and the header-length helper function of the GSE packet deframer.
package gsed_pkg;

  // Bytes of baseband frame header skipped at the start of every frame.
  localparam int FRAME_HEADER_BYTES = 10;
  // Width of the running totals; they wrap at this width.
  localparam int COUNTER_BITS = 32;

  // Byte class codes.
  localparam logic [1:0] CLS_FRAME_HDR = 2'd0;
  localparam logic [1:0] CLS_GSE_HDR   = 2'd1;
  localparam logic [1:0] CLS_PAYLOAD   = 2'd2;
  localparam logic [1:0] CLS_PADDING   = 2'd3;

  // Fields of the first GSE header byte.
  localparam logic [7:0] GSE_S_FLAG = 8'h80;
  localparam logic [7:0] GSE_E_FLAG = 8'h40;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  byte_class;
    logic        payload_valid;
    logic        payload_last;
    logic        length_error;
    logic [31:0] frame_total;
    logic [31:0] packet_total;
    logic [31:0] data_byte_total;
    logic [31:0] header_byte_total;
    logic [31:0] payload_byte_total;
    logic [31:0] padding_byte_total;
  } out_item_t;

  // Per-byte outcome of the parser: classification plus counter updates.
  typedef struct packed {
    logic [1:0]  cls;
    logic        plast;
    logic        err;
    logic        frame_inc;
    logic        data_inc;
    logic        pkt_inc;
    logic        pad_inc;
    logic [3:0]  hdr_add;
    logic [11:0] pay_add;
  } psr_res_t;

  // GSE header length in bytes, taken from the first header byte. For an end
  // fragment the trailing CRC is counted as header.
  function automatic logic [3:0] gse_header_len(input logic [7:0] b1);
    logic [3:0] lab;
    logic       s;
    logic       e;
    logic [3:0] len;
    case (b1[5:4])
      2'b00:   lab = 4'd6;
      2'b01:   lab = 4'd3;
      default: lab = 4'd0;
    endcase
    s = (b1 & GSE_S_FLAG) != 8'h00;
    e = (b1 & GSE_E_FLAG) != 8'h00;
    if (s && e) begin
      len = 4'd4 + lab;
    end else if (s) begin
      len = 4'd7 + lab;
    end else if (e) begin
      len = 4'd7;
    end else begin
      len = 4'd3;
    end
    return len;
  endfunction

endpackage

>>> src/gse_packet_deframer.sv
// Top level of the GSE packet deframer: handshake stages, counters and config.
//
//  Channel   Direction  Handshake            Payload
//  in_*      input      in_valid / in_stall  in_item_t  (data_byte, frame_last)
//  out_*     output     out_valid/out_stall  out_item_t (byte, class, flags, totals)
//  cfg_*     input      cfg_valid/cfg_ready  cfg_data   (forward_enable)
//
// One byte is taken per clock cycle while in_stall is low. A byte passes from the
// input register through the parse step into the result register, from which
// its result transfers out. The parse step between the input register and the
// result register is combinational.
// rst_n is synchronous and clears the parse state, counters, valid flags and
// forward_enable. A stall on the output holds the result register; the input
// register keeps taking bytes until it is also full, then in_stall rises.
module gse_packet_deframer
  import gsed_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  logic      in_vld_r;
  in_item_t  in_r;
  logic      out_vld_r;
  out_item_t out_r;
  logic      fwd_en_r;
  logic      move;
  logic      in_take;
  psr_res_t  res;

  logic [COUNTER_BITS-1:0] frame_cnt_r, frame_cnt_nxt;
  logic [COUNTER_BITS-1:0] pkt_cnt_r, pkt_cnt_nxt;
  logic [COUNTER_BITS-1:0] data_cnt_r, data_cnt_nxt;
  logic [COUNTER_BITS-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [COUNTER_BITS-1:0] pay_cnt_r, pay_cnt_nxt;
  logic [COUNTER_BITS-1:0] pad_cnt_r, pad_cnt_nxt;

  // The held byte moves into the result register whenever that register is
  // empty or its current result is being transferred out.
  assign move      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !move;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

  gsed_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (move),
    .item  (in_r),
    .res   (res)
  );

  // Running totals after the current byte; they wrap at COUNTER_BITS.
  assign frame_cnt_nxt = frame_cnt_r + COUNTER_BITS'(res.frame_inc);
  assign pkt_cnt_nxt   = pkt_cnt_r + COUNTER_BITS'(res.pkt_inc);
  assign data_cnt_nxt  = data_cnt_r + COUNTER_BITS'(res.data_inc);
  assign hdr_cnt_nxt   = hdr_cnt_r + COUNTER_BITS'(res.hdr_add);
  assign pay_cnt_nxt   = pay_cnt_r + COUNTER_BITS'(res.pay_add);
  assign pad_cnt_nxt   = pad_cnt_r + COUNTER_BITS'(res.pad_inc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_en_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      fwd_en_r <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (move) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_item;
    end
  end

  // Counters and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r   <= 1'b0;
      frame_cnt_r <= '0;
      pkt_cnt_r   <= '0;
      data_cnt_r  <= '0;
      hdr_cnt_r   <= '0;
      pay_cnt_r   <= '0;
      pad_cnt_r   <= '0;
    end else if (move) begin
      out_vld_r   <= 1'b1;
      frame_cnt_r <= frame_cnt_nxt;
      pkt_cnt_r   <= pkt_cnt_nxt;
      data_cnt_r  <= data_cnt_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      pay_cnt_r   <= pay_cnt_nxt;
      pad_cnt_r   <= pad_cnt_nxt;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_r.out_byte           <= in_r.data_byte;
      out_r.byte_class         <= res.cls;
      out_r.payload_valid      <= (res.cls == CLS_PAYLOAD) && fwd_en_r;
      out_r.payload_last       <= res.plast;
      out_r.length_error       <= res.err;
      out_r.frame_total        <= 32'(frame_cnt_nxt);
      out_r.packet_total       <= 32'(pkt_cnt_nxt);
      out_r.data_byte_total    <= 32'(data_cnt_nxt);
      out_r.header_byte_total  <= 32'(hdr_cnt_nxt);
      out_r.payload_byte_total <= 32'(pay_cnt_nxt);
      out_r.padding_byte_total <= 32'(pad_cnt_nxt);
    end
  end

endmodule

>>> src/gsed_parser.sv
// Per-byte phase machine that walks frame headers, GSE packets and padding.
module gsed_parser
  import gsed_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  in_item_t item,
  output psr_res_t res
);

  typedef enum logic [4:0] {
    PH_SKIP   = 5'b00001,
    PH_FIRST  = 5'b00010,
    PH_SECOND = 5'b00100,
    PH_BODY   = 5'b01000,
    PH_PAD    = 5'b10000
  } phase_t;

  localparam phase_t PH_START = (FRAME_HEADER_BYTES == 0) ? PH_FIRST : PH_SKIP;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  skip_r, skip_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [3:0]  hdr_left_r, hdr_left_nxt;
  logic [11:0] pkt_left_r, pkt_left_nxt;
  logic [11:0] pay_len_r, pay_len_nxt;

  logic [7:0]  b;
  logic        last;
  logic [11:0] len;
  logic [3:0]  extra;
  logic        short_pkt;

  assign b         = item.data_byte;
  assign last      = item.frame_last;
  assign len       = {first_r[3:0], b};
  assign extra     = gse_header_len(first_r) - 4'd2;
  assign short_pkt = {8'd0, extra} > len;

  always_comb begin
    phase_nxt    = phase_r;
    skip_nxt     = skip_r;
    first_nxt    = first_r;
    hdr_left_nxt = hdr_left_r;
    pkt_left_nxt = pkt_left_r;
    pay_len_nxt  = pay_len_r;
    res          = '0;
    res.cls      = CLS_FRAME_HDR;

    case (phase_r)
      PH_SKIP: begin
        skip_nxt = skip_r + 4'd1;
        if (skip_nxt >= 4'(FRAME_HEADER_BYTES)) begin
          phase_nxt = PH_FIRST;
        end
      end
      PH_FIRST: begin
        res.data_inc = 1'b1;
        if (b[7:4] == 4'd0) begin
          res.cls     = CLS_PADDING;
          res.pad_inc = 1'b1;
          phase_nxt   = PH_PAD;
        end else begin
          res.cls     = CLS_GSE_HDR;
          res.pkt_inc = 1'b1;
          res.hdr_add = gse_header_len(b);
          first_nxt   = b;
          phase_nxt   = PH_SECOND;
          res.err     = last;
        end
      end
      PH_SECOND: begin
        res.data_inc = 1'b1;
        res.cls      = CLS_GSE_HDR;
        if (short_pkt) begin
          res.err      = 1'b1;
          hdr_left_nxt = len[3:0];
          pay_len_nxt  = 12'd0;
        end else begin
          hdr_left_nxt = extra;
          pay_len_nxt  = len - {8'd0, extra};
        end
        pkt_left_nxt = len;
        phase_nxt    = (len == 12'd0) ? PH_FIRST : PH_BODY;
        if (last && len != 12'd0) begin
          res.err = 1'b1;
        end
      end
      PH_BODY: begin
        res.data_inc = 1'b1;
        if (hdr_left_r != 4'd0) begin
          res.cls      = CLS_GSE_HDR;
          hdr_left_nxt = hdr_left_r - 4'd1;
        end else begin
          res.cls = CLS_PAYLOAD;
        end
        if (pkt_left_r != 12'd0) begin
          pkt_left_nxt = pkt_left_r - 12'd1;
        end
        if (pkt_left_nxt == 12'd0) begin
          res.plast   = (res.cls == CLS_PAYLOAD);
          res.pay_add = pay_len_r;
          phase_nxt   = PH_FIRST;
        end else if (last) begin
          res.err = 1'b1;
        end
      end
      PH_PAD: begin
        res.data_inc = 1'b1;
        res.cls      = CLS_PADDING;
        res.pad_inc  = 1'b1;
      end
      default: begin
        phase_nxt = PH_START;
      end
    endcase

    // The last byte of a frame closes it and restarts the header skip.
    if (last) begin
      res.frame_inc = 1'b1;
      phase_nxt     = PH_START;
      skip_nxt      = 4'd0;
      hdr_left_nxt  = 4'd0;
      pkt_left_nxt  = 12'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_START;
      skip_r     <= 4'd0;
      first_r    <= 8'd0;
      hdr_left_r <= 4'd0;
      pkt_left_r <= 12'd0;
      pay_len_r  <= 12'd0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      skip_r     <= skip_nxt;
      first_r    <= first_nxt;
      hdr_left_r <= hdr_left_nxt;
      pkt_left_r <= pkt_left_nxt;
      pay_len_r  <= pay_len_nxt;
    end
  end

endmodule

>>> src/gsed_checker.sv
// Port-level assertions for the GSE packet deframer and the bind that attaches them.
module gsed_checker
  import gsed_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // The input is only held off while a result waits under a stall.
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no waiting result");

  // Only payload bytes may be flagged for forwarding.
  a_fwd_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.payload_valid |-> out_item.byte_class == CLS_PAYLOAD)
    else $error("payload_valid on a non-payload byte");

  // The end of a packet's payload is itself a payload byte.
  a_last_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.payload_last |-> out_item.byte_class == CLS_PAYLOAD)
    else $error("payload_last on a non-payload byte");

  // Length errors are only raised inside a GSE packet.
  a_err_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.length_error |->
      out_item.byte_class == CLS_GSE_HDR || out_item.byte_class == CLS_PAYLOAD)
    else $error("length_error outside a GSE packet");

endmodule

bind gse_packet_deframer gsed_checker u_gsed_checker (.*);
